// File: rtl/core/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - shared definitions
// Default geometry, widest supported geometry, phase and command codes, and
// the command record handed from the token parser to the copy engine.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    // Default geometry
    localparam int OFFSET_BITS_DEF = 13;
    localparam int COUNT_BITS_DEF  = 4;
    localparam int MIN_MATCH_DEF   = 3;

    // Widest geometry the command record can carry
    localparam int OFFSET_BITS_MAX = 16;
    localparam int COUNT_BITS_MAX  = 8;
    localparam int LEN_W_MAX       = COUNT_BITS_MAX + 1;

    // Literal body length in bits
    localparam int LIT_BITS = 8;

    // Command queue depth between parser and copy engine
    localparam int CMD_FIFO_DEPTH = 4;

    // Token parser phase
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_LIT   = 2'd1,
        PH_MATCH = 2'd2
    } phase_t;

    // Command kinds
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_LIT  = 2'd1,
        CMD_COPY = 2'd2
    } cmd_kind_t;

    // Copy engine state
    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_COPY = 1'b1
    } back_state_t;

    // One decoded token, plus the end-of-stream mark of its input byte
    typedef struct packed {
        cmd_kind_t                  kind;
        logic [7:0]                 lit;
        logic [OFFSET_BITS_MAX-1:0] pos;
        logic [LEN_W_MAX-1:0]       len;
        logic                       last;
    } cmd_t;

endpackage

// File: rtl/core/lzwd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - compressed byte channel
// Valid/ready channel carrying one compressed byte and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface lzwd_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);

endinterface

// File: rtl/core/lzwd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - decompressed byte channel
// Valid/ready channel carrying one decompressed byte and its run-end mark.
// ----------------------------------------------------------------------------
interface lzwd_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);

endinterface

// File: rtl/core/lzss_window_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - top level
// Token parser, command queue and copy engine with its history window.
//
//   channel   direction  payload                  request moves
//   in_ch     sink       in_byte[7:0], stream_end  one compressed byte
//   out_ch    source     out_byte[7:0], run_last   one decompressed byte
//
// The parser takes one byte per cycle while the command queue has room.
// The copy engine emits a literal straight from idle. A copy of
// count+MIN_MATCH bytes first primes the window read port, then moves
// one byte a cycle while the output byte is not stalled.
// Reset leaves an empty window; a fill count stands in for clearing it, so
// there is no clearing pass. Either side may stall: a full queue holds off
// input, and an untaken output byte holds the copy engine.
// ----------------------------------------------------------------------------
module lzss_window_decompressor
    import lzwd_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int MIN_MATCH   = MIN_MATCH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lzwd_in_if.sink    in_ch,
    lzwd_out_if.source out_ch
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Parse tokens
    lzwd_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .MIN_MATCH   (MIN_MATCH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .fifo_full (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Queue commands
    lzwd_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Carry out commands against the window
    lzwd_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// File: rtl/core/lzwd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - token parser
// Takes one compressed byte per request, walks its eight bits MSB first and
// emits at most one literal or copy command per byte into the command queue.
// ----------------------------------------------------------------------------
module lzwd_front
    import lzwd_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int MIN_MATCH   = MIN_MATCH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    lzwd_in_if.sink  in_ch,
    input  logic     fifo_full,
    output logic     push,
    output cmd_t     push_cmd
);

    localparam int BODY_BITS = OFFSET_BITS + COUNT_BITS;
    localparam int GATH_W    = $clog2(BODY_BITS + 1);
    localparam int LEN_W     = COUNT_BITS + 1;

    phase_t               phase_reg, phase_next;
    logic [BODY_BITS-1:0] acc_reg, acc_next;
    logic [GATH_W-1:0]    gath_reg, gath_next;
    logic                 accept;
    logic                 emit;
    cmd_t                 cmd_v;

    assign in_ch.ready = !fifo_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Walk the byte bit by bit, tracking the token phase
    always_comb
    begin
        phase_t               ph;
        logic [BODY_BITS-1:0] acc;
        logic [GATH_W-1:0]    gath;
        logic                 bit_v;
        logic                 last_bit;
        logic [LEN_W-1:0]     len_v;

        ph       = phase_reg;
        acc      = acc_reg;
        gath     = gath_reg;
        emit     = 1'b0;
        cmd_v    = '0;
        cmd_v.kind = CMD_NONE;
        len_v    = '0;
        for (int b = 7; b >= 0; b--)
        begin
            bit_v    = in_ch.in_byte[b];
            last_bit = in_ch.stream_end && (b == 0);
            if (ph == PH_FLAG)
            begin
                ph   = bit_v ? PH_LIT : PH_MATCH;
                acc  = '0;
                gath = '0;
            end
            else
            begin
                acc  = {acc[BODY_BITS-2:0], bit_v};
                gath = gath + GATH_W'(1);
                if (ph == PH_LIT)
                begin
                    if (gath >= GATH_W'(LIT_BITS))
                    begin
                        // drop a token that ends on the last bit of the stream
                        if (!last_bit)
                        begin
                            emit       = 1'b1;
                            cmd_v.kind = CMD_LIT;
                            cmd_v.lit  = acc[7:0];
                        end
                        ph = PH_FLAG;
                    end
                end
                else if (gath >= GATH_W'(BODY_BITS))
                begin
                    if (!last_bit)
                    begin
                        len_v      = {1'b0, acc[COUNT_BITS-1:0]} + LEN_W'(MIN_MATCH);
                        emit       = 1'b1;
                        cmd_v.kind = CMD_COPY;
                        cmd_v.pos  = OFFSET_BITS_MAX'(acc[BODY_BITS-1:COUNT_BITS]);
                        cmd_v.len  = LEN_W_MAX'(len_v);
                    end
                    ph = PH_FLAG;
                end
            end
        end
        cmd_v.last = in_ch.stream_end;

        // return to the start of a stream after its final byte
        if (in_ch.stream_end)
        begin
            phase_next = PH_FLAG;
            acc_next   = '0;
            gath_next  = '0;
        end
        else
        begin
            phase_next = ph;
            acc_next   = acc;
            gath_next  = gath;
        end
    end

    // Queue a command for a finished token or for the end of a stream
    assign push     = accept && (emit || in_ch.stream_end);
    assign push_cmd = cmd_v;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            acc_reg   <= '0;
            gath_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            gath_reg  <= gath_next;
        end
    end

endmodule

// File: rtl/core/lzwd_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - command queue
// Short first-in first-out queue of decoded commands between the token
// parser and the copy engine.
// ----------------------------------------------------------------------------
module lzwd_cmd_fifo
    import lzwd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             entries [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/lzwd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor - copy engine
// Carries out queued commands against the history window. Literals are
// written and emitted together; copies read the window one byte a cycle
// unless output stalls, writing each back, with self-overlap forwarding.
// ----------------------------------------------------------------------------
module lzwd_back
    import lzwd_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    lzwd_out_if.source out_ch
);

    localparam int WIN_SIZE = 1 << OFFSET_BITS;
    localparam int LEN_W    = COUNT_BITS + 1;

    logic [7:0]             window_mem [WIN_SIZE];

    back_state_t            state_reg, state_next;
    logic [OFFSET_BITS-1:0] wp_reg, wp_next;
    logic                   wrapped_reg, wrapped_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic                   end_reg, end_next;
    logic [OFFSET_BITS-1:0] rd_ptr_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   run_last_reg, run_last_next;

    logic [7:0]             mem_q_reg;
    logic                   hit_reg;
    logic [7:0]             fwd_reg;
    logic                   rd_valid_reg;

    logic                   advance;
    logic                   rd_en;
    logic [OFFSET_BITS-1:0] rd_addr;
    logic                   wr_en;
    logic [7:0]             wr_data;
    logic                   out_load;
    logic                   clear;
    logic [7:0]             rd_data;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.run_last = run_last_reg;

    // Take a new result when the output register is empty or being drained
    assign advance = !out_valid_reg || out_ch.ready;

    // Window byte: forwarded write, stored byte, or zero if not yet written
    assign rd_data = hit_reg ? fwd_reg : (rd_valid_reg ? mem_q_reg : 8'h00);

    // Command sequencing
    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg + OFFSET_BITS'(1);
        wr_en         = 1'b0;
        wr_data       = rd_data;
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;
        run_last_next = run_last_reg;
        rem_next      = rem_reg;
        end_next      = end_reg;
        clear         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head_cmd.kind)
                        CMD_LIT:
                        begin
                            if (advance)
                            begin
                                pop           = 1'b1;
                                wr_en         = 1'b1;
                                wr_data       = head_cmd.lit;
                                out_load      = 1'b1;
                                out_byte_next = head_cmd.lit;
                                run_last_next = 1'b1;
                                clear         = head_cmd.last;
                            end
                        end
                        CMD_COPY:
                        begin
                            // issue the first read; source starts one below the position
                            pop        = 1'b1;
                            rd_en      = 1'b1;
                            rd_addr    = head_cmd.pos[OFFSET_BITS-1:0] - OFFSET_BITS'(1);
                            rem_next   = head_cmd.len[LEN_W-1:0];
                            end_next   = head_cmd.last;
                            state_next = BK_COPY;
                        end
                        default:
                        begin
                            // end of stream with nothing to emit
                            pop   = 1'b1;
                            clear = head_cmd.last;
                        end
                    endcase
                end
            end
            BK_COPY:
            begin
                if (advance)
                begin
                    wr_en         = 1'b1;
                    out_load      = 1'b1;
                    out_byte_next = rd_data;
                    run_last_next = (rem_reg == LEN_W'(1));
                    rd_en         = 1'b1;
                    rem_next      = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                    begin
                        state_next = BK_IDLE;
                        clear      = end_reg;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // Fill tracking: write position plus a flag once the window has wrapped
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (wr_en)
        begin
            wp_next = wp_reg + OFFSET_BITS'(1);
            if (wp_reg == '1)
            begin
                wrapped_next = 1'b1;
            end
        end
        if (clear)
        begin
            wp_next      = '0;
            wrapped_next = 1'b0;
        end

        // Hold the output until taken
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            rem_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            rem_reg       <= rem_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    // Read side bookkeeping: address, forwarding and fill check
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_ptr_reg   <= rd_addr;
            hit_reg      <= wr_en && (rd_addr == wp_reg);
            fwd_reg      <= wr_data;
            rd_valid_reg <= wrapped_reg || (rd_addr < wp_reg);
        end
    end

    // Window write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[wp_reg] <= wr_data;
        end
    end

    // Window read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= window_mem[rd_addr];
        end
    end

endmodule
